// File: design/u16u8_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the code point encoder for the string reader.
// No dependencies; imported by every module of the block.
package u16u8_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] MODE_UTF8  = 2'd1;
    localparam logic [1:0] MODE_UTF16 = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;

    localparam logic [20:0] CP_MAX1   = 21'h00007F;
    localparam logic [20:0] CP_MAX2   = 21'h0007FF;
    localparam logic [20:0] CP_MAX3   = 21'h00FFFF;
    localparam logic [20:0] SURR_BASE = 21'h010000;

    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_DETECT = 5'b00010,
        PH_UTF8   = 5'b00100,
        PH_UTF16  = 5'b01000,
        PH_DRAIN  = 5'b10000
    } t_phase;

    // Work for the back end: up to four string bytes, then an optional status item
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      nbytes;
        logic            has_st;
        logic [1:0]      st;
    } t_cmd;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      nbytes;
    } t_enc;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic [1:0] status;
        logic       run_last;
    } t_res;

    function automatic t_enc encode_cp(input logic [20:0] cp);
        t_enc e;
        e = '0;
        if (cp <= CP_MAX1) begin
            e.nbytes   = 3'd1;
            e.bytes[0] = cp[7:0];
        end else if (cp <= CP_MAX2) begin
            e.nbytes   = 3'd2;
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= CP_MAX3) begin
            e.nbytes   = 3'd3;
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            e.nbytes   = 3'd4;
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
        end
        return e;
    endfunction

endpackage

// File: design/u16u8_front.sv
`timescale 1ns / 1ps
// Front end: tracks string phase, detects encoding, assembles UTF-16 units
// and turns each accepted beat into at most one back-end command. Uses u16u8_pkg.
module u16u8_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_mode,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_before_start,
    input  logic              i_span_last,
    output logic              o_push,
    output u16u8_pkg::t_cmd   o_cmd
);
    import u16u8_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_held, n_held;
    logic        r_half, n_half;
    logic [9:0]  r_hs, n_hs;
    logic        r_sp, n_sp;
    logic        r_emitted, n_emitted;

    t_cmd        cmd;
    t_enc        enc;
    logic        unit_go;
    logic [15:0] unit;
    logic [20:0] cp;
    logic        unit_high, unit_low;

    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        n_half    = r_half;
        n_hs      = r_hs;
        n_sp      = r_sp;
        n_emitted = r_emitted;
        cmd       = '0;
        unit_go   = 1'b0;
        unit      = '0;
        cp        = '0;
        enc       = '0;

        if (!i_before_start) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_mode == MODE_UTF8) begin
                        if (i_data_byte == 8'd0) begin
                            cmd.has_st = 1'b1;
                            cmd.st     = ST_OK;
                            n_phase    = PH_DRAIN;
                        end else begin
                            cmd.bytes[0] = i_data_byte;
                            cmd.nbytes   = 3'd1;
                            n_emitted    = 1'b1;
                            n_phase      = PH_UTF8;
                        end
                    end else if (i_mode == MODE_UTF16) begin
                        n_phase = PH_UTF16;
                        n_held  = i_data_byte;
                        n_half  = 1'b1;
                    end else begin
                        n_held  = i_data_byte;
                        n_phase = PH_DETECT;
                    end
                end
                PH_DETECT: begin
                    if (i_data_byte == 8'd0 && r_held != 8'd0) begin
                        n_phase = PH_UTF16;
                        unit_go = 1'b1;
                        unit    = {8'd0, r_held};
                    end else if (r_held == 8'd0) begin
                        cmd.has_st = 1'b1;
                        cmd.st     = ST_OK;
                        n_phase    = PH_DRAIN;
                    end else begin
                        cmd.bytes[0] = r_held;
                        cmd.nbytes   = 3'd1;
                        n_emitted    = 1'b1;
                        n_phase      = PH_UTF8;
                        if (i_data_byte == 8'd0) begin
                            cmd.has_st = 1'b1;
                            cmd.st     = ST_OK;
                            n_phase    = PH_DRAIN;
                        end else begin
                            cmd.bytes[1] = i_data_byte;
                            cmd.nbytes   = 3'd2;
                        end
                    end
                end
                PH_UTF8: begin
                    if (i_data_byte == 8'd0) begin
                        cmd.has_st = 1'b1;
                        cmd.st     = ST_OK;
                        n_phase    = PH_DRAIN;
                    end else begin
                        cmd.bytes[0] = i_data_byte;
                        cmd.nbytes   = 3'd1;
                        n_emitted    = 1'b1;
                    end
                end
                PH_UTF16: begin
                    if (!r_half) begin
                        n_held = i_data_byte;
                        n_half = 1'b1;
                    end else begin
                        n_half  = 1'b0;
                        unit_go = 1'b1;
                        unit    = {i_data_byte, r_held};
                    end
                end
                PH_DRAIN: begin
                end
                default: begin
                end
            endcase
        end

        unit_high = (unit[15:10] == HIGH_SURR_TAG);
        unit_low  = (unit[15:10] == LOW_SURR_TAG);

        // One complete 16-bit unit
        if (unit_go) begin
            if (r_sp) begin
                n_sp = 1'b0;
                if (unit_low) begin
                    cp         = SURR_BASE + {1'b0, r_hs, unit[9:0]};
                    enc        = encode_cp(cp);
                    cmd.bytes  = enc.bytes;
                    cmd.nbytes = enc.nbytes;
                    n_emitted  = 1'b1;
                end else begin
                    cmd.has_st = 1'b1;
                    cmd.st     = ST_ILLEGAL;
                    n_phase    = PH_DRAIN;
                end
            end else if (unit == 16'd0) begin
                cmd.has_st = 1'b1;
                cmd.st     = ST_OK;
                n_phase    = PH_DRAIN;
            end else if (unit_high) begin
                n_hs = unit[9:0];
                n_sp = 1'b1;
            end else if (unit_low) begin
                cmd.has_st = 1'b1;
                cmd.st     = ST_ILLEGAL;
                n_phase    = PH_DRAIN;
            end else begin
                cp         = {5'd0, unit};
                enc        = encode_cp(cp);
                cmd.bytes  = enc.bytes;
                cmd.nbytes = enc.nbytes;
                n_emitted  = 1'b1;
            end
        end

        // End of span: close the string if still open, then start afresh
        if (i_span_last) begin
            unique case (n_phase)
                PH_IDLE: begin
                    cmd.has_st = 1'b1;
                    cmd.st     = ST_EMPTY;
                end
                PH_DETECT: begin
                    cmd.has_st = 1'b1;
                    cmd.st     = ST_OK;
                    if (n_held != 8'd0) begin
                        cmd.bytes[cmd.nbytes[1:0]] = n_held;
                        cmd.nbytes                 = cmd.nbytes + 3'd1;
                    end
                end
                PH_UTF8: begin
                    cmd.has_st = 1'b1;
                    cmd.st     = n_emitted ? ST_OK : ST_ILLEGAL;
                end
                PH_UTF16: begin
                    cmd.has_st = 1'b1;
                    cmd.st     = (n_half || n_sp) ? ST_ILLEGAL : ST_OK;
                end
                PH_DRAIN: begin
                end
                default: begin
                end
            endcase
            n_phase   = PH_IDLE;
            n_held    = '0;
            n_half    = 1'b0;
            n_hs      = '0;
            n_sp      = 1'b0;
            n_emitted = 1'b0;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = i_accept && (cmd.nbytes != 3'd0 || cmd.has_st);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_held    <= '0;
            r_half    <= 1'b0;
            r_hs      <= '0;
            r_sp      <= 1'b0;
            r_emitted <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_held    <= n_held;
            r_half    <= n_half;
            r_hs      <= n_hs;
            r_sp      <= n_sp;
            r_emitted <= n_emitted;
        end
    end

endmodule

// File: design/u16u8_fifo.sv
`timescale 1ns / 1ps
// Command queue between front and back ends, QDEPTH entries in flops.
// Uses t_cmd and queue sizing from u16u8_pkg.
module u16u8_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u16u8_pkg::t_cmd   i_cmd,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_nonempty,
    output u16u8_pkg::t_cmd   o_head
);
    import u16u8_pkg::*;

    t_cmd               r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_cnt, n_cnt;
    logic               do_push, do_pop;

    assign o_full     = (r_cnt == QCNT_W'(QDEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        unique case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + QCNT_W'(1);
            2'b01:   n_cnt = r_cnt - QCNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_cmd;
    end

endmodule

// File: design/u16u8_back.sv
`timescale 1ns / 1ps
// Back end: unrolls one command into result beats, one per cycle while the output
// is not stalled, into a registered output stage. Uses t_cmd and t_res from u16u8_pkg.
module u16u8_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  u16u8_pkg::t_cmd   i_q_cmd,
    output logic              o_pop,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output u16u8_pkg::t_res   o_res
);
    import u16u8_pkg::*;

    t_cmd        r_cmd;
    logic        r_cmd_vld;
    logic [2:0]  r_idx;
    logic        r_out_vld;
    t_res        r_res, n_res;

    logic        out_free, emit, is_last, cmd_free;
    logic [2:0]  total;

    assign out_free = !r_out_vld || !i_out_stall;
    assign emit     = r_cmd_vld && out_free;
    assign total    = r_cmd.nbytes + {2'b00, r_cmd.has_st};
    assign is_last  = (r_idx == total - 3'd1);
    assign cmd_free = !r_cmd_vld || (emit && is_last);
    assign o_pop    = cmd_free && i_q_valid;

    always_comb begin
        n_res          = '0;
        n_res.run_last = is_last;
        if (r_idx < r_cmd.nbytes) begin
            n_res.out_byte   = r_cmd.bytes[r_idx[1:0]];
            n_res.byte_valid = 1'b1;
        end else begin
            n_res.string_done = 1'b1;
            n_res.status      = r_cmd.st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_vld <= 1'b0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cmd_vld <= 1'b1;
                r_idx     <= '0;
            end else if (emit && is_last) begin
                r_cmd_vld <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + 3'd1;
            end

            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cmd <= i_q_cmd;
        if (emit)  r_res <= n_res;
    end

    assign o_out_valid = r_out_vld;
    assign o_res       = r_res;

endmodule

// File: design/utf16le_to_utf8_string_reader_core.sv
`timescale 1ns / 1ps
// String reader top: front end, 4-entry command queue, back end, mode register.
// A beat's command passes through the queue and the back end's command register
// to the registered output stage. Throughput: one input beat per cycle while the
// queue has room; the back end delivers one result per cycle while not stalled.
// Reset (synchronous, active low) clears phase, queue, output stage and mode.
module utf16le_to_utf8_string_reader_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_before_start,
    input  logic        i_span_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_string_done,
    output logic [1:0]  o_status,
    output logic        o_run_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data
);
    import u16u8_pkg::*;

    logic [1:0] r_mode;
    logic       accept, push, pop, q_full, q_nonempty;
    t_cmd       front_cmd, head_cmd;
    t_res       res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign accept      = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    u16u8_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (r_mode),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_before_start (i_before_start),
        .i_span_last    (i_span_last),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    u16u8_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (front_cmd),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (head_cmd)
    );

    u16u8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_nonempty),
        .i_q_cmd     (head_cmd),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (res)
    );

    assign o_out_byte    = res.out_byte;
    assign o_byte_valid  = res.byte_valid;
    assign o_string_done = res.string_done;
    assign o_status      = res.status;
    assign o_run_last    = res.run_last;

    // A status beat always closes the results of its input beat
    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_string_done |-> o_run_last)
        else $error("status beat without run_last");

    a_status_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_string_done |-> !o_byte_valid && o_out_byte == 8'd0)
        else $error("status beat carries a byte");

    a_byte_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_valid |-> !o_string_done && o_status == ST_OK)
        else $error("byte beat carries a status");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("command pushed into a full queue");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for utf16le_to_utf8_string_reader_core: random spans, mode changes, stalls.
// Depends on u16u8_pkg for result layout, phase and code constants; no files, no arguments.
import u16u8_pkg::*;

// Expected UTF-8 bytes and end-of-string status items, worked out beat by beat
class utf8_result_board;
    t_res       pending_results[$];
    t_res       beat_results[$];
    t_phase     phase;
    logic [1:0] mode;
    logic [7:0] held;
    bit         half_held;
    logic [9:0] high_bits;
    bit         high_pending;
    bit         emitted;
    int         n_beats;
    int         n_results;
    int         n_errors;
    int         n_by_status[4];

    function new();
        mode = 2'd0;
        clear_string();
    endfunction

    function void clear_string();
        phase        = PH_IDLE;
        held         = 8'h00;
        half_held    = 1'b0;
        high_bits    = 10'd0;
        high_pending = 1'b0;
        emitted      = 1'b0;
    endfunction

    function void push(logic [7:0] b, bit valid, bit done, logic [1:0] st);
        t_res r;
        r.out_byte    = b;
        r.byte_valid  = valid;
        r.string_done = done;
        r.status      = st;
        r.run_last    = 1'b0;
        if (done)
            n_by_status[st]++;
        beat_results.insert(beat_results.size(), r);
    endfunction

    function void emit(logic [7:0] b);
        push(b, 1'b1, 1'b0, ST_OK);
        emitted = 1'b1;
    endfunction

    function void close_string(logic [1:0] st);
        push(8'h00, 1'b0, 1'b1, st);
        phase = PH_DRAIN;
    endfunction

    // Lead byte carries the top bits, then six bits per continuation byte
    function void emit_code_point(logic [20:0] cp);
        int         n;
        logic [7:0] lead;
        n = (cp <= 21'h7F) ? 1 : (cp <= 21'h7FF) ? 2 : (cp <= 21'hFFFF) ? 3 : 4;
        if (n == 1) begin
            emit(cp[7:0]);
        end else begin
            lead = (n == 2) ? 8'hC0 : (n == 3) ? 8'hE0 : 8'hF0;
            emit(lead | 8'(cp >> (6 * (n - 1))));
            for (int k = n - 2; k >= 0; k--)
                emit(8'h80 | 8'((cp >> (6 * k)) & 21'h3F));
        end
    endfunction

    function void utf8_in(logic [7:0] b);
        if (b == 8'h00)
            close_string(ST_OK);
        else
            emit(b);
    endfunction

    function void unit_in(logic [15:0] u);
        if (high_pending) begin
            high_pending = 1'b0;
            if (u >= 16'hDC00 && u <= 16'hDFFF)
                emit_code_point(21'h10000 + (21'(high_bits) << 10) + 21'(u[9:0]));
            else
                close_string(ST_ILLEGAL);
        end else if (u == 16'h0000) begin
            close_string(ST_OK);
        end else if (u >= 16'hD800 && u <= 16'hDBFF) begin
            high_bits    = u[9:0];
            high_pending = 1'b1;
        end else if (u >= 16'hDC00 && u <= 16'hDFFF) begin
            close_string(ST_ILLEGAL);
        end else begin
            emit_code_point(21'(u));
        end
    endfunction

    function void utf16_byte_in(logic [7:0] b);
        if (!half_held) begin
            held      = b;
            half_held = 1'b1;
        end else begin
            half_held = 1'b0;
            unit_in({b, held});
        end
    endfunction

    function void data_in(logic [7:0] b);
        case (phase)
            PH_IDLE: begin
                if (mode == MODE_UTF8) begin
                    phase = PH_UTF8;
                    utf8_in(b);
                end else if (mode == MODE_UTF16) begin
                    phase = PH_UTF16;
                    utf16_byte_in(b);
                end else begin
                    held  = b;
                    phase = PH_DETECT;
                end
            end
            PH_DETECT: begin
                if (b == 8'h00 && held != 8'h00) begin
                    phase = PH_UTF16;
                    unit_in({8'h00, held});
                end else begin
                    phase = PH_UTF8;
                    utf8_in(held);
                    if (phase == PH_UTF8)
                        utf8_in(b);
                end
            end
            PH_UTF8:  utf8_in(b);
            PH_UTF16: utf16_byte_in(b);
            default: ;
        endcase
    endfunction

    function void span_end();
        case (phase)
            PH_IDLE: push(8'h00, 1'b0, 1'b1, ST_EMPTY);
            PH_DETECT: begin
                phase = PH_UTF8;
                utf8_in(held);
                if (phase == PH_UTF8)
                    close_string(emitted ? ST_OK : ST_ILLEGAL);
            end
            PH_UTF8:  close_string(emitted ? ST_OK : ST_ILLEGAL);
            PH_UTF16: close_string((half_held || high_pending) ? ST_ILLEGAL : ST_OK);
            default: ;
        endcase
        clear_string();
    endfunction

    function void note_beat(logic [7:0] b, bit skip, bit last);
        beat_results.delete();
        if (!skip)
            data_in(b);
        if (last)
            span_end();
        if (beat_results.size() > 0)
            beat_results[beat_results.size() - 1].run_last = 1'b1;
        foreach (beat_results[k])
            pending_results.insert(pending_results.size(), beat_results[k]);
        n_beats++;
    endfunction

    function void note_mode(logic [1:0] m);
        mode = m;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    task report_mismatch(string what);
        n_errors++;
        $display("MISMATCH: %s", what);
    endtask

    task compare_field(string name, int got_v, int want_v);
        if (got_v != want_v)
            report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                      n_results, name, got_v, want_v));
    endtask

    task check_result(t_res got);
        t_res want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result: byte %02h valid %0d done %0d status %0d",
                                      got.out_byte, got.byte_valid, got.string_done, got.status));
            return;
        end
        want = pending_results.pop_front();
        n_results++;
        compare_field("out_byte", got.out_byte, want.out_byte);
        compare_field("byte_valid", got.byte_valid, want.byte_valid);
        compare_field("string_done", got.string_done, want.string_done);
        compare_field("status", got.status, want.status);
        compare_field("run_last", got.run_last, want.run_last);
    endtask
endclass

module testbench;

    localparam logic [1:0] MODE_AUTO     = 2'd0;
    localparam logic [1:0] MODE_AUTO_ALT = 2'd3;
    localparam int RANDOM_ITEMS  = 250;
    localparam int PHASE_ITEMS   = 30;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 10;
    localparam int IDLE_LIMIT    = 2000;

    typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_TOGGLE} t_flow;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_before_start = 1'b0;
    logic       i_span_last = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_string_done;
    logic [1:0] o_status;
    logic       o_run_last;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_data = 2'd0;

    utf8_result_board sb = new();

    logic [7:0] span_bytes[$];
    bit         span_skip[$];
    int         burst_left;
    int         random_items;
    int         n_mode_writes;
    int         n_holds;
    int         idle_cycles;
    bit         hold_req;

    utf16le_to_utf8_string_reader_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_before_start (i_before_start),
        .i_span_last    (i_span_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_string_done  (o_string_done),
        .o_status       (o_status),
        .o_run_last     (o_run_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drive one beat and hold it until the block takes it; bursts with random gaps
    task automatic send_beat(input logic [7:0] b, input bit skip, input bit last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_data_byte    <= b;
        i_before_start <= skip;
        i_span_last    <= last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_beat(b, skip, last);
        @(negedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.note_mode(m);
        n_mode_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop sending, wait for every expected result, then let the pipeline settle
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function void add_byte(logic [7:0] b, bit skip);
        span_bytes.insert(span_bytes.size(), b);
        span_skip.insert(span_skip.size(), skip);
    endfunction

    // Tail after the terminator: discarded by the block
    function void add_tail();
        repeat ($urandom_range(0, 3)) begin
            span_bytes.insert(span_bytes.size(), 8'($urandom_range(0, 255)));
            span_skip.insert(span_skip.size(), bit'($urandom_range(0, 1)));
        end
    endfunction

    function void add_unit(logic [15:0] u);
        add_byte(u[7:0], 1'b0);
        if ($urandom_range(0, 11) == 0)
            add_byte(8'($urandom_range(0, 255)), 1'b1);
        add_byte(u[15:8], 1'b0);
    endfunction

    function logic [15:0] bmp_unit();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(16'h0001, 16'h007F));
            1:       return 16'($urandom_range(16'h0080, 16'h07FF));
            2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    function void build_span(logic [1:0] m);
        int  kind;
        int  ending;
        bit  auto_mode;
        logic [7:0] b;
        span_bytes.delete();
        span_skip.delete();
        kind      = $urandom_range(0, 99);
        auto_mode = (m == MODE_AUTO || m == MODE_AUTO_ALT);
        repeat ($urandom_range(0, 2))
            add_byte(8'($urandom_range(0, 255)), 1'b1);
        if (kind < 8) begin
            if (span_bytes.size() == 0)
                add_byte(8'($urandom_range(0, 255)), 1'b1);
        end else if (kind < 25) begin
            // noise: lean on zeros and surrogate-looking bytes
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(0, 7))
                    0:       b = 8'h00;
                    1:       b = 8'hD8;
                    2:       b = 8'hDC;
                    3:       b = 8'hFF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                add_byte(b, $urandom_range(0, 6) == 0);
            end
        end else if (m == MODE_UTF16 || (auto_mode && $urandom_range(0, 1))) begin
            if (auto_mode)
                add_unit({8'h00, 8'($urandom_range(1, 255))});
            repeat ($urandom_range(0, 5)) begin
                if ($urandom_range(0, 4) == 0) begin
                    add_unit(16'hD800 + 16'($urandom_range(0, 1023)));
                    add_unit(($urandom_range(0, 19) == 0) ? bmp_unit()
                             : 16'hDC00 + 16'($urandom_range(0, 1023)));
                end else begin
                    add_unit(bmp_unit());
                end
            end
            ending = $urandom_range(0, 9);
            if (ending < 7) begin
                add_unit(16'h0000);
                add_tail();
            end else if (ending == 8) begin
                add_byte(8'($urandom_range(0, 255)), 1'b0);
            end else if (ending == 9) begin
                add_unit(16'hD800 + 16'($urandom_range(0, 1023)));
            end
        end else begin
            repeat ($urandom_range(1, 6))
                add_byte(8'($urandom_range(1, 255)), 1'b0);
            if ($urandom_range(0, 9) < 7) begin
                add_byte(8'h00, 1'b0);
                add_tail();
            end
        end
    endfunction

    task automatic send_span(input logic [1:0] m);
        build_span(m);
        foreach (span_bytes[k])
            send_beat(span_bytes[k], span_skip[k], k == span_bytes.size() - 1);
        random_items += span_bytes.size();
    endtask

    // Receiver: own stall pattern, plus one long hold-off on request
    initial begin
        t_flow style;
        int    seg_left;
        style    = FLOW_FREE;
        seg_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
                n_holds++;
            end else begin
                if (seg_left == 0) begin
                    style    = t_flow'($urandom_range(0, 3));
                    seg_left = $urandom_range(8, 48);
                end
                seg_left--;
                case (style)
                    FLOW_FREE:  i_out_stall <= 1'b0;
                    FLOW_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    FLOW_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default:    i_out_stall <= ~i_out_stall;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result({o_out_byte, o_byte_valid, o_string_done, o_status, o_run_last});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, sb.pending());
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [1:0] m;
        int         phase_no;
        int         phase_start;
        burst_left    = 0;
        random_items  = 0;
        n_mode_writes = 0;
        n_holds       = 0;
        idle_cycles   = 0;
        hold_req      = 1'b0;
        phase_no      = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(MODE_AUTO);
        send_beat(8'hFF, 1'b1, 1'b1);   // empty span: only a skipped byte
        send_beat(8'h41, 1'b0, 1'b1);   // lone byte in auto mode reads as UTF-8
        send_beat(8'h41, 1'b0, 1'b0);   // 'A' little-endian selects UTF-16
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b0);   // U+FFFF, three bytes
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);   // skipped byte mid-string
        send_beat(8'h3D, 1'b0, 1'b0);   // surrogate pair, four bytes
        send_beat(8'hD8, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hDE, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);   // terminator
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'h55, 1'b0, 1'b1);   // drop: after the terminator
        send_beat(8'h00, 1'b0, 1'b1);   // null as the only byte
        drain_and_settle();

        write_mode(MODE_UTF16);
        send_beat(8'h00, 1'b0, 1'b0);   // lone low surrogate
        send_beat(8'hDC, 1'b0, 1'b0);
        send_beat(8'h41, 1'b0, 1'b1);
        send_beat(8'h00, 1'b0, 1'b0);   // high surrogate then a zero unit
        send_beat(8'hD8, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'h41, 1'b0, 1'b1);   // half unit at span end

        while (random_items < RANDOM_ITEMS) begin
            drain_and_settle();
            case (phase_no)
                0:       m = MODE_UTF8;
                1:       m = MODE_AUTO_ALT;
                2:       m = MODE_UTF16;
                3:       m = MODE_AUTO;
                default: m = 2'($urandom_range(0, 3));
            endcase
            write_mode(m);
            if (phase_no == 1)
                hold_req = 1'b1;
            phase_start = random_items;
            while (random_items - phase_start < PHASE_ITEMS && random_items < RANDOM_ITEMS)
                send_span(m);
            phase_no++;
        end
        drain_and_settle();

        $display("Covered %0d beats in %0d mode phases, %0d mode writes, %0d long hold-offs",
                 sb.n_beats, phase_no, n_mode_writes, n_holds);
        $display("Checked %0d results; strings ended ok %0d, empty %0d, illegal %0d",
                 sb.n_results, sb.n_by_status[ST_OK], sb.n_by_status[ST_EMPTY],
                 sb.n_by_status[ST_ILLEGAL]);
        if (sb.n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
